// ----- design/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ----- design/irr_pkg.sv -----
package irr_pkg;

  localparam int CFG_DATA_W = 20;
  localparam int TIMER_W = 20;
  localparam int HALF_W = 10;
  localparam int SAMPLES_W = 4;
  localparam int TAG_W = 8;
  localparam int CM_W = 7;
  localparam int BYTE_W = 8;
  localparam int BITPOS_W = 4;

  localparam int TABLE_ENTRIES = 9;
  localparam int CM_PER_STEP = 10;
  localparam logic [BITPOS_W-1:0] BITS_PER_BYTE = 4'd8;

  localparam logic [BYTE_W-1:0] THRESHOLDS [TABLE_ENTRIES] = '{
    8'd190, 8'd135, 8'd107, 8'd95, 8'd87, 8'd80, 8'd77, 8'd75, 8'd0
  };

  typedef enum logic [1:0] {
    CFG_READY_TIMEOUT = 2'd0,
    CFG_REST          = 2'd1,
    CFG_HALF_BIT      = 2'd2,
    CFG_SAMPLES       = 2'd3
  } irr_cfg_index_t;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_START = 6'b000010,
    PH_RETRY = 6'b000100,
    PH_LEAD  = 6'b001000,
    PH_READ  = 6'b010000,
    PH_REST  = 6'b100000
  } irr_phase_t;

  typedef struct packed {
    logic [TIMER_W-1:0]   ready_timeout_ticks;
    logic [TIMER_W-1:0]   rest_ticks;
    logic [HALF_W-1:0]    half_bit_ticks;
    logic [SAMPLES_W-1:0] samples_per_reading;
  } irr_cfg_t;

  typedef struct packed {
    logic             trigger;
    logic [TAG_W-1:0] requester;
    logic             sensor_level;
  } irr_item_t;

  typedef struct packed {
    logic             clock_drive;
    logic             done_res;
    logic [CM_W-1:0]  distance_cm;
    logic [TAG_W-1:0] client_tag;
    logic             rejected;
    logic             timed_out;
    logic             busy_res;
  } irr_res_t;

  // Priority search of the threshold table; the last entry always matches.
  function automatic logic [CM_W-1:0] to_cm(input logic [BYTE_W-1:0] value);
    logic [CM_W-1:0] cm;
    cm = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (value >= THRESHOLDS[i]) begin
        cm = CM_W'((i + 1) * CM_PER_STEP);
      end
    end
    return cm;
  endfunction

endpackage

// ----- design/irr_req_if.sv -----
interface irr_req_if import irr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             trigger;
  logic [TAG_W-1:0] requester;
  logic             sensor_level;

  modport source (output valid, output trigger, output requester, output sensor_level,
                  input ready);
  modport sink (input valid, input trigger, input requester, input sensor_level,
                output ready);
endinterface

// ----- design/irr_res_if.sv -----
interface irr_res_if import irr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             clock_drive;
  logic             done_res;
  logic [CM_W-1:0]  distance_cm;
  logic [TAG_W-1:0] client_tag;
  logic             rejected;
  logic             timed_out;
  logic             busy_res;

  modport source (output valid, output clock_drive, output done_res, output distance_cm,
                  output client_tag, output rejected, output timed_out, output busy_res,
                  input ready);
  modport sink (input valid, input clock_drive, input done_res, input distance_cm,
                input client_tag, input rejected, input timed_out, input busy_res,
                output ready);
endinterface

// ----- design/ir_ranger_serial_reader_core.sv -----
// Infrared ranger readout controller. Each request transaction is one
// microsecond tick and yields exactly one result transaction, in order. A tick
// is taken in every cycle in which the result side keeps up: the tick is held
// in an input register, the sequencer works out the new state and the result
// in one pass, and the result register then offers it. A stall on the result
// side holds both registers, and the input register still takes one more
// tick while the result waits. The user must write registers through the
// configuration port only while no tick is in flight, unchecked by the block.
`include "assert_macros.svh"

module ir_ranger_serial_reader_core import irr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  irr_req_if.sink               req_ch,
  irr_res_if.source             res_ch
);

  irr_cfg_t  cfg;
  irr_item_t item;
  irr_res_t  res_comb;
  irr_res_t  res_reg;
  logic      item_valid;
  logic      out_valid;
  logic      out_free;
  logic      adv;

  assign out_free = !out_valid || res_ch.ready;
  assign adv = item_valid && out_free;
  assign req_ch.ready = !item_valid || out_free;

  irr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req_ch.ready) begin
      item_valid <= req_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ch.ready && req_ch.valid) begin
      item.trigger <= req_ch.trigger;
      item.requester <= req_ch.requester;
      item.sensor_level <= req_ch.sensor_level;
    end
  end

  irr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (adv),
    .item (item),
    .res  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_reg <= res_comb;
    end
  end

  assign res_ch.valid = out_valid;
  assign res_ch.clock_drive = res_reg.clock_drive;
  assign res_ch.done_res = res_reg.done_res;
  assign res_ch.distance_cm = res_reg.distance_cm;
  assign res_ch.client_tag = res_reg.client_tag;
  assign res_ch.rejected = res_reg.rejected;
  assign res_ch.timed_out = res_reg.timed_out;
  assign res_ch.busy_res = res_reg.busy_res;

  `ASSERT_NEXT(a_adv_fills_out, clk, rst, adv, out_valid)
  `ASSERT_NEXT(a_stall_holds_item, clk, rst, item_valid && out_valid && !res_ch.ready,
               item_valid)

endmodule

// ----- design/irr_cfg_regs.sv -----
module irr_cfg_regs import irr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output irr_cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ready_timeout_ticks <= 20'd200000;
      cfg.rest_ticks <= 20'd5000;
      cfg.half_bit_ticks <= 10'd35;
      cfg.samples_per_reading <= 4'd1;
    end else if (cfg_we) begin
      case (irr_cfg_index_t'(cfg_index))
        CFG_READY_TIMEOUT: cfg.ready_timeout_ticks <= cfg_wdata[TIMER_W-1:0];
        CFG_REST:          cfg.rest_ticks <= cfg_wdata[TIMER_W-1:0];
        CFG_HALF_BIT:      cfg.half_bit_ticks <= cfg_wdata[HALF_W-1:0];
        CFG_SAMPLES:       cfg.samples_per_reading <= cfg_wdata[SAMPLES_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- design/irr_ctrl.sv -----
`include "assert_macros.svh"

module irr_ctrl import irr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  irr_cfg_t  cfg,
  input  logic      step,
  input  irr_item_t item,
  output irr_res_t  res
);

  irr_phase_t           phase, phase_next;
  logic [TIMER_W-1:0]   tick_timer, tick_timer_next;
  logic [BITPOS_W-1:0]  bit_position, bit_position_next;
  logic [BYTE_W-1:0]    shift_byte, shift_byte_next;
  logic [CM_W-1:0]      best_distance, best_distance_next;
  logic [SAMPLES_W-1:0] samples_taken, samples_taken_next;
  logic [TAG_W-1:0]     saved_tag, saved_tag_next;
  logic                 last_level;
  logic                 clock_level, clock_level_next;

  logic [TIMER_W-1:0]   timer_inc;
  logic [TIMER_W-1:0]   period;
  logic                 expired;
  logic [BYTE_W-1:0]    sample_byte;
  logic [BITPOS_W-1:0]  bit_inc;
  logic [SAMPLES_W-1:0] taken_inc;
  logic [CM_W-1:0]      sample_cm;
  logic                 done;
  logic                 timed_out;

  assign timer_inc = tick_timer + 1'b1;
  assign sample_byte = {shift_byte[BYTE_W-2:0], item.sensor_level};
  assign bit_inc = bit_position + 1'b1;
  assign taken_inc = samples_taken + 1'b1;
  assign sample_cm = to_cm(sample_byte);

  always_comb begin
    case (phase)
      PH_START:         period = cfg.ready_timeout_ticks;
      PH_RETRY, PH_REST: period = cfg.rest_ticks;
      default:          period = TIMER_W'(cfg.half_bit_ticks);
    endcase
  end

  assign expired = (timer_inc >= period);

  always_comb begin
    phase_next = phase;
    tick_timer_next = tick_timer;
    bit_position_next = bit_position;
    shift_byte_next = shift_byte;
    best_distance_next = best_distance;
    samples_taken_next = samples_taken;
    saved_tag_next = saved_tag;
    clock_level_next = clock_level;
    done = 1'b0;
    timed_out = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (item.trigger) begin
          saved_tag_next = item.requester;
          best_distance_next = '0;
          samples_taken_next = '0;
          clock_level_next = 1'b0;
          tick_timer_next = '0;
          phase_next = PH_START;
        end
      end
      PH_START: begin
        if (!last_level && item.sensor_level) begin
          tick_timer_next = '0;
          bit_position_next = '0;
          shift_byte_next = '0;
          phase_next = PH_LEAD;
        end else begin
          tick_timer_next = expired ? '0 : timer_inc;
          if (expired) begin
            timed_out = 1'b1;
            clock_level_next = 1'b1;
            phase_next = PH_RETRY;
          end
        end
      end
      PH_RETRY: begin
        tick_timer_next = expired ? '0 : timer_inc;
        if (expired) begin
          clock_level_next = 1'b0;
          phase_next = PH_START;
        end
      end
      PH_LEAD: begin
        tick_timer_next = expired ? '0 : timer_inc;
        if (expired) begin
          clock_level_next = 1'b1;
          phase_next = PH_READ;
        end
      end
      PH_READ: begin
        tick_timer_next = expired ? '0 : timer_inc;
        if (expired) begin
          if (clock_level) begin
            clock_level_next = 1'b0;
          end else begin
            shift_byte_next = sample_byte;
            bit_position_next = bit_inc;
            clock_level_next = 1'b1;
            if (bit_inc >= BITS_PER_BYTE) begin
              if (sample_cm > best_distance) begin
                best_distance_next = sample_cm;
              end
              samples_taken_next = taken_inc;
              done = (taken_inc >= cfg.samples_per_reading);
              phase_next = PH_REST;
            end
          end
        end
      end
      PH_REST: begin
        tick_timer_next = expired ? '0 : timer_inc;
        if (expired) begin
          if (samples_taken >= cfg.samples_per_reading) begin
            phase_next = PH_IDLE;
          end else begin
            clock_level_next = 1'b0;
            phase_next = PH_START;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
        clock_level_next = 1'b1;
        tick_timer_next = '0;
      end
    endcase
  end

  always_comb begin
    res.clock_drive = clock_level_next;
    res.done_res = done;
    res.distance_cm = done ? best_distance_next : '0;
    res.client_tag = done ? saved_tag_next : '0;
    res.rejected = item.trigger && (phase != PH_IDLE);
    res.timed_out = timed_out;
    res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      tick_timer <= '0;
      bit_position <= '0;
      shift_byte <= '0;
      best_distance <= '0;
      samples_taken <= '0;
      saved_tag <= '0;
      last_level <= 1'b0;
      clock_level <= 1'b1;
    end else if (step) begin
      phase <= phase_next;
      tick_timer <= tick_timer_next;
      bit_position <= bit_position_next;
      shift_byte <= shift_byte_next;
      best_distance <= best_distance_next;
      samples_taken <= samples_taken_next;
      saved_tag <= saved_tag_next;
      last_level <= item.sensor_level;
      clock_level <= clock_level_next;
    end
  end

  `ASSERT_IMPL(a_idle_line_high, clk, rst, phase == PH_IDLE, clock_level)
  `ASSERT_IMPL(a_start_line_low, clk, rst, phase == PH_START, !clock_level)
  `ASSERT_NEXT(a_done_then_rest, clk, rst, step && res.done_res, phase == PH_REST)

endmodule
